// File: rtl/tstb_pkg.sv
// ---------------------------------------------------------------------------
// tstb_pkg
// Shared types and constants of the tag session table with ack backoff.
// ---------------------------------------------------------------------------
package tstb_pkg;

   localparam int TAG_W       = 32;
   localparam int SESS_W      = 8;
   localparam int AP_ID_W     = 31;
   localparam int MOD_W       = 4;
   localparam int SLOT_W      = 4;
   localparam int BACKOFF_W   = 6;

   localparam logic [MOD_W-1:0] MOD_START = 4'd12;
   localparam logic [MOD_W-1:0] MOD_FLOOR = 4'd6;
   localparam int MOD_COUNT   = 7;
   localparam int MOD_IDX_W   = 3;
   localparam int BACKOFF_SHIFT = 2;

   // residue sweep: ap_id padded to DIGIT_W*DIGIT_STEPS bits, msb digit first
   localparam int DIGIT_W     = 4;
   localparam int DIGIT_STEPS = 8;
   localparam int SWEEP_W     = DIGIT_W * DIGIT_STEPS;
   localparam int STEP_W      = 3;

   typedef struct packed {
      logic [TAG_W-1:0]  tag_id;
      logic [SESS_W-1:0] session_id;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic                 evicted;
      logic [SLOT_W-1:0]    slot;
      logic [MOD_W-1:0]     modulus;
      logic [BACKOFF_W-1:0] backoff_units;
   } rsp_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [SESS_W-1:0] session;
      logic [MOD_W-1:0]  modulus;
   } entry_type;

   typedef logic [MOD_COUNT-1:0][MOD_W-1:0] residue_set_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic read;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic more;
      logic match;
      logic scan_done;
   } dp_status_type;

endpackage

// File: rtl/tstb_resid.sv
// ---------------------------------------------------------------------------
// tstb_resid
// Holds ap_id and sweeps it once per write into its residues modulo 6..12.
// ---------------------------------------------------------------------------
module tstb_resid (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [tstb_pkg::AP_ID_W-1:0]       wr_data,
   output logic                               busy,
   output tstb_pkg::residue_set_type          residues
);

   logic [tstb_pkg::SWEEP_W-1:0]  ap_ff;
   logic [tstb_pkg::SWEEP_W-1:0]  ap_in;
   logic [tstb_pkg::STEP_W-1:0]   step_ff;
   logic [tstb_pkg::STEP_W-1:0]   step_in;
   logic                          busy_ff;
   logic                          busy_in;
   tstb_pkg::residue_set_type     rem_ff;
   tstb_pkg::residue_set_type     rem_in;
   tstb_pkg::residue_set_type     rem_step;
   logic [tstb_pkg::DIGIT_W-1:0]  digit;

   assign digit = ap_ff[tstb_pkg::SWEEP_W-1 -: tstb_pkg::DIGIT_W];

   // one digit per cycle in each lane, remainder stays below the lane's modulus
   always_comb begin
      logic [tstb_pkg::MOD_W:0] t;
      logic [tstb_pkg::MOD_W:0] m;
      for (int l = 0; l < tstb_pkg::MOD_COUNT; l++) begin
         m = (tstb_pkg::MOD_W+1)'(tstb_pkg::MOD_FLOOR) + (tstb_pkg::MOD_W+1)'(l);
         t = {1'b0, rem_ff[l]};
         for (int b = tstb_pkg::DIGIT_W - 1; b >= 0; b--) begin
            t = {t[tstb_pkg::MOD_W-1:0], digit[b]};
            if (t >= m) begin
               t = t - m;
            end
         end
         rem_step[l] = t[tstb_pkg::MOD_W-1:0];
      end
   end

   always_comb begin
      ap_in   = ap_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      rem_in  = rem_ff;
      priority if (wr_en) begin
         ap_in   = tstb_pkg::SWEEP_W'(wr_data);
         step_in = '0;
         busy_in = 1'b1;
         rem_in  = '0;
      end else if (busy_ff) begin
         ap_in   = ap_ff << tstb_pkg::DIGIT_W;
         step_in = step_ff + 1'b1;
         busy_in = (step_ff != tstb_pkg::STEP_W'(tstb_pkg::DIGIT_STEPS - 1));
         rem_in  = rem_step;
      end
   end

   always_ff @(posedge clock) begin
      ap_ff <= ap_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         rem_ff  <= '0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         rem_ff  <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign residues = rem_ff;

   a_write_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> busy_ff && (step_ff == '0))
      else $error("residue sweep did not restart after ap_id write");

endmodule

// File: rtl/tstb_dp.sv
// ---------------------------------------------------------------------------
// tstb_dp
// Table memory, linear tag scan, fifo victim pointer, entry update and the
// result register.
// ---------------------------------------------------------------------------
module tstb_dp #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tstb_pkg::dp_cmd_type          cmd,
   output tstb_pkg::dp_status_type       status,
   input  tstb_pkg::req_type             req_data,
   input  tstb_pkg::residue_set_type     residues,
   output tstb_pkg::rsp_type             rsp_data
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);
   localparam logic [IW-1:0] LAST_SLOT  = IW'(TABLE_ENTRIES - 1);

   tstb_pkg::entry_type mem [TABLE_ENTRIES];

   tstb_pkg::req_type   item_ff;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [CW-1:0]       scan_ff;
   logic [CW-1:0]       scan_in;
   logic [IW-1:0]       victim_ff;
   logic [IW-1:0]       victim_in;
   tstb_pkg::entry_type rd_data_ff;
   logic [IW-1:0]       rd_addr_ff;
   logic                rd_vld_ff;
   logic                rd_vld_in;
   tstb_pkg::rsp_type   rsp_ff;

   logic                      match;
   logic                      full;
   logic [IW-1:0]             wr_slot;
   tstb_pkg::entry_type       wr_entry;
   tstb_pkg::rsp_type         result;
   logic [tstb_pkg::MOD_IDX_W-1:0] res_idx;

   assign match = rd_vld_ff && (rd_data_ff.tag == item_ff.tag_id);
   assign full  = (count_ff == FULL_COUNT);

   assign status.empty     = (count_ff == '0);
   assign status.more      = (scan_ff < count_ff);
   assign status.match     = match;
   assign status.scan_done = rd_vld_ff && ((CW'(rd_addr_ff) + 1'b1) == count_ff);

   // entry written back at commit, and the result it produces
   always_comb begin
      wr_entry.tag     = item_ff.tag_id;
      wr_entry.session = item_ff.session_id;
      wr_entry.modulus = tstb_pkg::MOD_START;
      priority if (match) begin
         wr_slot = rd_addr_ff;
         if (rd_data_ff.session == item_ff.session_id) begin
            wr_entry.modulus = (rd_data_ff.modulus == tstb_pkg::MOD_FLOOR) ?
               tstb_pkg::MOD_START : rd_data_ff.modulus - 1'b1;
         end
      end else if (full) begin
         wr_slot = victim_ff;
      end else begin
         wr_slot = count_ff[IW-1:0];
      end
      res_idx = tstb_pkg::MOD_IDX_W'(wr_entry.modulus - tstb_pkg::MOD_FLOOR);
      result.hit           = match;
      result.evicted       = !match && full;
      result.slot          = tstb_pkg::SLOT_W'(wr_slot);
      result.modulus       = wr_entry.modulus;
      result.backoff_units = tstb_pkg::BACKOFF_W'({residues[res_idx],
                                                   tstb_pkg::BACKOFF_SHIFT'(0)});
   end

   always_comb begin
      count_in  = count_ff;
      victim_in = victim_ff;
      scan_in   = scan_ff;
      rd_vld_in = rd_vld_ff;
      if (cmd.start) begin
         scan_in   = '0;
         rd_vld_in = 1'b0;
      end
      if (cmd.read) begin
         scan_in   = scan_ff + 1'b1;
         rd_vld_in = 1'b1;
      end
      if (cmd.commit && !match) begin
         if (full) begin
            // replacement order is first in, first out over the slots
            victim_in = (victim_ff == LAST_SLOT) ? '0 : victim_ff + 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         item_ff <= req_data;
      end
      if (cmd.read) begin
         rd_data_ff <= mem[scan_ff[IW-1:0]];
         rd_addr_ff <= scan_ff[IW-1:0];
      end
      if (cmd.commit) begin
         mem[wr_slot] <= wr_entry;
         rsp_ff       <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         victim_ff <= '0;
         scan_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         victim_ff <= victim_in;
         scan_ff   <= scan_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   assign rsp_data = rsp_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond table size");

   a_hit_keeps_count: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && match |=> $stable(count_ff) && $stable(victim_ff))
      else $error("hit changed fill count or victim pointer");

endmodule

// File: rtl/tstb_ctrl.sv
// ---------------------------------------------------------------------------
// tstb_ctrl
// Sequencer: accept, scan the table, commit the entry and hold the result.
// ---------------------------------------------------------------------------
module tstb_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic                     resid_busy,
   input  tstb_pkg::dp_status_type  status,
   output tstb_pkg::dp_cmd_type     cmd
);

   tstb_pkg::state_type state_ff;
   tstb_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tstb_pkg::ST_IDLE: begin
            if (req_valid && !resid_busy) begin
               state_in = status.empty ? tstb_pkg::ST_COMMIT : tstb_pkg::ST_SEARCH;
            end
         end
         tstb_pkg::ST_SEARCH: begin
            if (status.match || status.scan_done) begin
               state_in = tstb_pkg::ST_COMMIT;
            end
         end
         tstb_pkg::ST_COMMIT: begin
            if (out_free) begin
               state_in = tstb_pkg::ST_IDLE;
            end
         end
         default: state_in = tstb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.start  = 1'b0;
      cmd.read   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         tstb_pkg::ST_IDLE: begin
            req_ready = !resid_busy;
            cmd.start = req_valid && !resid_busy;
         end
         tstb_pkg::ST_SEARCH: begin
            // stop reading once matched so the hit entry stays in the read register
            cmd.read = status.more && !status.match;
         end
         tstb_pkg::ST_COMMIT: begin
            cmd.commit = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tstb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != tstb_pkg::ST_IDLE)
      else $error("accepted transaction did not start work");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("response raised without a commit");

endmodule

// File: rtl/tag_session_table_backoff_unit.sv
// ---------------------------------------------------------------------------
// tag_session_table_backoff_unit
// Tag table with per-session backoff modulus and fifo replacement; each
// uplink transaction returns hit, eviction, slot, modulus and ack backoff.
// ---------------------------------------------------------------------------
//  channel | ports                        | carries
//  --------+------------------------------+---------------------------------
//  req     | req_valid/req_ready/req_data | tag_id, session_id
//  rsp     | rsp_valid/rsp_ready/rsp_data | hit, evicted, slot, modulus, backoff
//  csr     | csr_valid/csr_ready/csr_data | ap_id
//
//  a miss scans every entry held (at most TABLE_ENTRIES), a hit stops at
//  the matching slot and an empty table skips the scan: the table memory
//  is scanned one entry per cycle.
//  a csr write sweeps ap_id into residues; req_ready is low during the sweep.
//  after reset the table is empty and the residues are 0, as for ap_id 0; no clearing pass.
//  a stalled rsp holds the result register; the next transaction is taken
//  and scanned meanwhile, and commits once the result has left.
// ---------------------------------------------------------------------------
module tag_session_table_backoff_unit #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tstb_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tstb_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tstb_pkg::AP_ID_W-1:0]  csr_data
);

   tstb_pkg::dp_cmd_type      cmd;
   tstb_pkg::dp_status_type   status;
   tstb_pkg::residue_set_type residues;
   logic                      resid_busy;

   assign csr_ready = 1'b1;

   tstb_resid u_resid (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_data  (csr_data),
      .busy     (resid_busy),
      .residues (residues)
   );

   tstb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .resid_busy (resid_busy),
      .status     (status),
      .cmd        (cmd)
   );

   tstb_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .residues (residues),
      .rsp_data (rsp_data)
   );

endmodule

// File: verif/tag_session_table_backoff_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tag_session_table_backoff_unit_tb
// Drives uplink transactions through the tag table and checks every ack
// against a predictor that mirrors the table, the fifo ages and the modulus
// walk. The sender idles in bursts and the receiver stalls on its own
// pattern. ap_id is rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------
module tag_session_table_backoff_unit_tb;

   localparam int TABLE_ENTRIES = 16;
   localparam int SETTLE_CYCLES = TABLE_ENTRIES + 3;
   localparam int TAIL_CYCLES   = 2 * (TABLE_ENTRIES + 3) + 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_LIMIT    = 2000;
   localparam int POOL_MAX      = 32;

   typedef enum int {RX_STEADY, RX_RANDOM, RX_HOLD} rx_mode_type;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   tstb_pkg::req_type              req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   tstb_pkg::rsp_type              rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [tstb_pkg::AP_ID_W-1:0]   csr_data  = '0;

   // predictor state
   logic [tstb_pkg::TAG_W-1:0]     tbl_tag     [TABLE_ENTRIES];
   logic [tstb_pkg::SESS_W-1:0]    tbl_session [TABLE_ENTRIES];
   logic [tstb_pkg::MOD_W-1:0]     tbl_modulus [TABLE_ENTRIES];
   int                             tbl_age     [TABLE_ENTRIES];
   int                             tbl_count   = 0;
   logic [tstb_pkg::AP_ID_W-1:0]   ap_id_shadow = '0;

   tstb_pkg::rsp_type              pending_acks [$];

   logic [tstb_pkg::TAG_W-1:0]     pool_tag     [POOL_MAX];
   logic [tstb_pkg::SESS_W-1:0]    pool_session [POOL_MAX];

   int                   fail_count    = 0;
   int                   events_sent   = 0;
   int                   acks_checked  = 0;
   int                   hits_seen     = 0;
   int                   evicts_seen   = 0;
   int                   csr_writes    = 0;

   bit                   tx_bursty     = 1'b0;
   int                   burst_left    = 0;
   rx_mode_type          rx_mode       = RX_STEADY;
   int                   hold_count    = 0;
   int                   rx_phase_left = 0;
   int                   rx_stall_pct  = 0;
   int                   idle_cycles   = 0;

   tag_session_table_backoff_unit #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // predictor: table lookup, fifo replacement, modulus step and backoff
   // ------------------------------------------------------------------------
   function automatic tstb_pkg::rsp_type lookup_tag_event(tstb_pkg::req_type ev);
      tstb_pkg::rsp_type ack;
      int      slot;
      int      i;
      bit      found;
      ack   = '0;
      slot  = 0;
      found = 1'b0;
      for (i = 0; i < tbl_count; i++) begin
         if (!found && tbl_tag[i] == ev.tag_id) begin
            found = 1'b1;
            slot  = i;
         end
      end
      if (found) begin
         if (tbl_session[slot] == ev.session_id) begin
            tbl_modulus[slot] = (tbl_modulus[slot] == tstb_pkg::MOD_FLOOR) ?
                                tstb_pkg::MOD_START : tbl_modulus[slot] - 1'b1;
         end else begin
            tbl_session[slot] = ev.session_id;
            tbl_modulus[slot] = tstb_pkg::MOD_START;
         end
      end else if (tbl_count < TABLE_ENTRIES) begin
         slot              = tbl_count;
         tbl_age[slot]     = tbl_count;
         tbl_count         = tbl_count + 1;
      end else begin
         ack.evicted = 1'b1;
         // smallest age goes, lowest slot on a tie
         for (i = 1; i < TABLE_ENTRIES; i++) begin
            if (tbl_age[i] < tbl_age[slot]) slot = i;
         end
         for (i = 0; i < TABLE_ENTRIES; i++) begin
            if (i != slot && tbl_age[i] > 0) tbl_age[i]--;
         end
         tbl_age[slot] = TABLE_ENTRIES - 1;
      end
      if (!found) begin
         tbl_tag[slot]     = ev.tag_id;
         tbl_session[slot] = ev.session_id;
         tbl_modulus[slot] = tstb_pkg::MOD_START;
      end
      ack.hit     = found;
      ack.slot    = tstb_pkg::SLOT_W'(slot);
      ack.modulus = tbl_modulus[slot];
      if (tbl_modulus[slot] != '0) begin
         ack.backoff_units = tstb_pkg::BACKOFF_W'((ap_id_shadow % tbl_modulus[slot])
                                                  << tstb_pkg::BACKOFF_SHIFT);
      end
      return ack;
   endfunction

   // ------------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------------
   task automatic send_event(input logic [tstb_pkg::TAG_W-1:0] tag,
                             input logic [tstb_pkg::SESS_W-1:0] session);
      tstb_pkg::req_type ev;
      int      gap;
      gap = 0;
      ev  = '{tag_id: tag, session_id: session};
      if (tx_bursty) begin
         if (burst_left == 0) begin
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 14);
         end
         burst_left--;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (!req_ready);
      pending_acks.push_back(lookup_tag_event(ev));
      events_sent++;
   endtask

   task automatic wait_acks_drained();
      req_valid <= 1'b0;
      while (pending_acks.size() != 0) @(posedge clock);
   endtask

   task automatic write_ap_id(input logic [tstb_pkg::AP_ID_W-1:0] value);
      wait_acks_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      ap_id_shadow = value;
      csr_writes++;
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // receiver stall pattern; a hold is counted here
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rx_mode == RX_HOLD && hold_count < HOLD_CYCLES) begin
         hold_count++;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode != RX_HOLD) hold_count = 0;
         if (rx_mode == RX_STEADY) begin
            rsp_ready <= 1'b1;
         end else begin
            if (rx_phase_left == 0) begin
               case ($urandom_range(0, 3))
                  0: rx_stall_pct = 0;
                  1: rx_stall_pct = 25;
                  2: rx_stall_pct = 60;
                  default: rx_stall_pct = 90;
               endcase
               rx_phase_left = $urandom_range(4, 40);
            end
            rx_phase_left--;
            rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // ack checker
   // ------------------------------------------------------------------------
   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      tstb_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_acks.size() == 0) begin
            $error("rsp: transaction with no ack pending");
            fail_count++;
         end else begin
            want = pending_acks.pop_front();
            compare_field("hit", 8'(want.hit), 8'(rsp_data.hit));
            compare_field("evicted", 8'(want.evicted), 8'(rsp_data.evicted));
            compare_field("slot", 8'(want.slot), 8'(rsp_data.slot));
            compare_field("modulus", 8'(want.modulus), 8'(rsp_data.modulus));
            compare_field("backoff_units", 8'(want.backoff_units),
                          8'(rsp_data.backoff_units));
            acks_checked++;
            hits_seen   += want.hit;
            evicts_seen += want.evicted;
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tag_session_table_backoff_unit regression: fail");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_first_entries();
      // ap_id still at its reset value, so backoff is zero
      send_event(32'h0000_0000, 8'h00);
      send_event(32'hFFFF_FFFF, 8'hFF);
   endtask

   task automatic test_modulus_walk();
      write_ap_id(31'h7FFF_FFFF);
      // same session walks 11 down to 6, then wraps to 12
      repeat (7) send_event(32'h0000_0000, 8'h00);
      send_event(32'h0000_0000, 8'h01);
      send_event(32'hFFFF_FFFF, 8'hFF);
   endtask

   task automatic test_table_fill_and_evict();
      int i;
      for (i = 2; i < TABLE_ENTRIES; i++) begin
         send_event(32'h1000_0000 + 32'(i), tstb_pkg::SESS_W'(i));
      end
      // full table: oldest slots go first
      send_event(32'hA5A5_A5A5, 8'h5A);
      send_event(32'h5A5A_5A5A, 8'hA5);
      send_event(32'h1000_0003, 8'h03);
   endtask

   task automatic test_result_stall();
      int i;
      tx_bursty = 1'b0;
      rx_mode   = RX_HOLD;
      for (i = 0; i < 10; i++) send_event($urandom, tstb_pkg::SESS_W'($urandom));
      rx_mode = RX_RANDOM;
      wait_acks_drained();
      for (i = 0; i < 4; i++) send_event($urandom, tstb_pkg::SESS_W'($urandom));
   endtask

   task automatic test_random_traffic(input int n_events, input int pool_size);
      int i;
      int idx;
      for (i = 0; i < pool_size; i++) begin
         pool_tag[i]     = $urandom;
         pool_session[i] = tstb_pkg::SESS_W'($urandom);
      end
      for (i = 0; i < n_events; i++) begin
         if ($urandom_range(0, 9) < 8) begin
            idx = $urandom_range(0, pool_size - 1);
            if ($urandom_range(0, 4) == 0) pool_session[idx] = tstb_pkg::SESS_W'($urandom);
            send_event(pool_tag[idx], pool_session[idx]);
         end else begin
            send_event($urandom, tstb_pkg::SESS_W'($urandom));
         end
      end
   endtask

   initial begin
      logic [tstb_pkg::AP_ID_W-1:0] ap_setting [6];
      int                 pool_sizes [6];
      int                 p;
      ap_setting = '{31'd1, 31'd27720, 31'h0, 31'h7FFF_FFFF, 31'd12, 31'd0};
      pool_sizes = '{6, 14, 20, 32, 10, 24};
      ap_setting[5] = tstb_pkg::AP_ID_W'($urandom);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_first_entries();
      test_modulus_walk();
      tx_bursty = 1'b1;
      rx_mode   = RX_RANDOM;
      test_table_fill_and_evict();
      test_result_stall();

      for (p = 0; p < 6; p++) begin
         write_ap_id(ap_setting[p]);
         // first phase runs with no idling on either side
         tx_bursty = (p != 0);
         rx_mode   = (p == 0) ? RX_STEADY : RX_RANDOM;
         test_random_traffic(180, pool_sizes[p]);
      end

      wait_acks_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d uplink events, %0d acks checked (%0d hits, %0d evictions)",
               events_sent, acks_checked, hits_seen, evicts_seen);
      $display("with %0d ap_id writes, result hold-off and sender drain pause",
               csr_writes);
      if (fail_count == 0) begin
         $display("tag_session_table_backoff_unit regression: pass");
      end else begin
         $display("tag_session_table_backoff_unit regression: fail");
      end
      $finish;
   end

endmodule
